>>> hw/rtl/skt_pkg.sv
// skt_pkg: shared types and constants for the sorted key table
// depends on nothing; used by skt_cell and sorted_key_table_top
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

	// request codes on req_type
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_FIND   = 1'b1;

	// fixed port widths
	localparam int KEY_PORT_W = 32;
	localparam int POS_W      = 8;
	localparam int CNT_OUT_W  = 9;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_ENC
	} skt_state_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic capture;  // latch compare flags against the broadcast key
		logic shift;    // apply an insert at the boundary cell
	} skt_cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/skt_cell.sv
// skt_cell: one slot of the sorted key row, holds a key and its compare flags
// depends on skt_pkg (cell control struct)
`timescale 1ns / 1ps
`default_nettype none

module skt_cell #(
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 9,
	parameter int INDEX     = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire skt_pkg::skt_cell_ctl_t ctl,
	input  wire [KEY_WIDTH-1:0]         key_bcast,
	input  wire [CNT_W-1:0]             count,
	input  wire                         lt_in,
	input  wire [KEY_WIDTH-1:0]         key_left,
	output logic                        lt,
	output logic                        eq,
	output logic [KEY_WIDTH-1:0]        key_out
);

	logic [KEY_WIDTH-1:0] key_q;
	logic                 lt_q;
	logic                 eq_q;
	logic                 occ;

	assign occ = CNT_W'(INDEX) < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.capture) begin
			lt_q <= occ && (key_q < key_bcast);
			eq_q <= occ && (key_q == key_bcast);
		end
	end

	// keys at or above the insert slot move up one, the boundary cell takes the new key
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (!lt_in) begin
				key_q <= key_left;
			end else if (!lt_q) begin
				key_q <= key_bcast;
			end
		end
	end

	assign lt      = lt_q;
	assign eq      = eq_q;
	assign key_out = key_q;

endmodule

`default_nettype wire

>>> hw/rtl/skt_enc.sv
// skt_enc: one-hot to binary encoder for the boundary cell of the row
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module skt_enc #(
	parameter int N     = 256,
	parameter int IDX_W = 8
) (
	input  wire  [N-1:0]     onehot,
	output logic [IDX_W-1:0] idx,
	output logic             any
);

	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

	assign any = |onehot;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_key_table_top.sv
// sorted_key_table_top: ascending key table built as a row of compare/shift cells
// depends on skt_pkg, skt_cell, skt_enc
//
//   channel | dir | handshake           | beat contents
//   --------+-----+---------------------+--------------------------------------------
//   in      | in  | in_valid / in_ready | req_type, key
//   out     | out | out_valid/out_ready | position, found, full_reject, entry_count
//
// every request goes through accept, a compare cycle in which each cell
// latches key < k and key == k, and an encode cycle that finds the boundary
// cell, shifts the row on insert and loads the result register.
// the result register parts the two sides; the encode cycle holds while a
// previous result beat still waits, so a stalled output never loses a beat.
// reset clears the entry count, state and output valid; keys are left as is
// and only slots below the count are ever compared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_top #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        req_type,
	input  wire [31:0] key,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] position,
	output logic       found,
	output logic       full_reject,
	output logic [8:0] entry_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	skt_pkg::skt_state_t    state_q, state_d;
	skt_pkg::skt_cell_ctl_t ctl;

	logic                 req_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] key_in;
	logic [CNT_W-1:0]     count_q;
	logic                 full;
	logic                 commit;

	logic [CAPACITY-1:0]  lt_w;
	logic [CAPACITY-1:0]  eq_w;
	logic [CAPACITY-1:0]  lt_left;
	logic [CAPACITY-1:0]  boundary;
	logic [KEY_WIDTH-1:0] key_w [CAPACITY];
	logic [IDX_W-1:0]     slot;
	logic                 slot_any;
	logic                 hit;

	logic                 out_valid_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 found_q;
	logic                 reject_q;
	logic [CNT_W-1:0]     count_out_q;

	// key port is 32 bits; the table compares KEY_WIDTH bits
	generate
		if (KEY_WIDTH >= skt_pkg::KEY_PORT_W) begin : g_key_ext
			assign key_in = KEY_WIDTH'(key);
		end else begin : g_key_trunc
			assign key_in = key[KEY_WIDTH-1:0];
		end
	endgenerate

	assign full = count_q == CNT_W'(CAPACITY);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		commit      = 1'b0;
		ctl.capture = 1'b0;
		ctl.shift   = 1'b0;
		unique case (state_q)
			skt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = skt_pkg::ST_CMP;
				end
			end
			skt_pkg::ST_CMP: begin
				ctl.capture = 1'b1;
				state_d     = skt_pkg::ST_ENC;
			end
			skt_pkg::ST_ENC: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					commit    = 1'b1;
					ctl.shift = (req_q == skt_pkg::REQ_INSERT) && !full;
					state_d   = skt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::ST_IDLE;
			end
		endcase
	end

	// request register, loaded on the accepted beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_type;
			key_q <= key_in;
		end
	end

	// ---------------- cell row ----------------
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				// slot 0 sees an always-smaller neighbor on its left
				assign lt_left[gi] = 1'b1;
				skt_cell #(
					.KEY_WIDTH (KEY_WIDTH),
					.CNT_W     (CNT_W),
					.INDEX     (gi)
				) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctl       (ctl),
					.key_bcast (key_q),
					.count     (count_q),
					.lt_in     (lt_left[gi]),
					.key_left  (key_q),
					.lt        (lt_w[gi]),
					.eq        (eq_w[gi]),
					.key_out   (key_w[gi])
				);
			end else begin : g_rest
				assign lt_left[gi] = lt_w[gi-1];
				skt_cell #(
					.KEY_WIDTH (KEY_WIDTH),
					.CNT_W     (CNT_W),
					.INDEX     (gi)
				) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctl       (ctl),
					.key_bcast (key_q),
					.count     (count_q),
					.lt_in     (lt_left[gi]),
					.key_left  (key_w[gi-1]),
					.lt        (lt_w[gi]),
					.eq        (eq_w[gi]),
					.key_out   (key_w[gi])
				);
			end
		end
	endgenerate

	// sorted row: the less-than flags form a thermometer, its edge is the slot
	assign boundary = lt_left & ~lt_w;

	skt_enc #(
		.N     (CAPACITY),
		.IDX_W (IDX_W)
	) u_enc (
		.onehot (boundary),
		.idx    (slot),
		.any    (slot_any)
	);

	// the edge cell's eq flag already includes occupancy
	assign hit = |(boundary & eq_w);

	// ---------------- entry count ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.shift) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (req_q == skt_pkg::REQ_INSERT) begin
				pos_q       <= full ? '0 : slot;
				found_q     <= 1'b0;
				reject_q    <= full;
				count_out_q <= full ? count_q : count_q + CNT_W'(1);
			end else begin
				pos_q       <= (hit && slot_any) ? slot : '0;
				found_q     <= hit;
				reject_q    <= 1'b0;
				count_out_q <= count_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign full_reject = reject_q;

	generate
		if (IDX_W >= skt_pkg::POS_W) begin : g_pos_trunc
			assign position = pos_q[skt_pkg::POS_W-1:0];
		end else begin : g_pos_ext
			assign position = skt_pkg::POS_W'(pos_q);
		end
		if (CNT_W >= skt_pkg::CNT_OUT_W) begin : g_cnt_trunc
			assign entry_count = count_out_q[skt_pkg::CNT_OUT_W-1:0];
		end else begin : g_cnt_ext
			assign entry_count = skt_pkg::CNT_OUT_W'(count_out_q);
		end
	endgenerate

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_edge: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skt_pkg::ST_ENC |-> $onehot0(boundary))
		else $error("less-than flags are not a thermometer");

	a_insert_edge: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> slot_any)
		else $error("insert without a boundary cell");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("entry count did not advance on insert");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && reject_q))
		else $error("result both found and rejected");

endmodule

`default_nettype wire
